// ===== src/base64_stream_encoder_macros.svh =====
// ----------------------------------------------------------------------------
// Base64 stream encoder assertion macros
// Concurrent assertion wrappers shared by the encoder RTL. They compile away
// when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef BASE64_STREAM_ENCODER_MACROS_SVH
`define BASE64_STREAM_ENCODER_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define B64SE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, checked out of reset.
`define B64SE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define B64SE_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define B64SE_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ===== src/b64se_pkg.sv =====
// ----------------------------------------------------------------------------
// Base64 stream encoder package
// Shared types, constants and the alphabet lookup for the encoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package b64se_pkg;

   // Characters one input byte can produce at most.
   localparam int CharsMax = 4;
   // Default depth of the queue between front and back.
   localparam int QueueDepthDefault = 2;

   // Position within the three-byte group.
   localparam logic [1:0] PH_ZERO = 2'd0;
   localparam logic [1:0] PH_ONE  = 2'd1;
   localparam logic [1:0] PH_TWO  = 2'd2;

   localparam logic [7:0] PAD_CHAR = 8'h3D;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } b64se_req_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       end_of_text;
   } b64se_rsp_type;

   // Characters produced by one input byte, ready for serialisation.
   typedef struct packed {
      logic [CharsMax-1:0][7:0]       chars;
      logic [$clog2(CharsMax)-1:0]    last_idx;
      logic                           eot;
   } b64se_job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } b64se_qstat_type;

   typedef struct packed {
      logic [1:0] phase;
   } b64se_fstat_type;

   // Standard base64 alphabet, computed from the six-bit value.
   function automatic logic [7:0] b64_sym(input logic [5:0] v);
      logic [7:0] r;
      if (v < 6'd26) begin
         r = 8'h41 + {2'b00, v};
      end else if (v < 6'd52) begin
         r = 8'h61 + {2'b00, v} - 8'd26;
      end else if (v < 6'd62) begin
         r = 8'h30 + {2'b00, v} - 8'd52;
      end else if (v == 6'd62) begin
         r = 8'h2B;
      end else begin
         r = 8'h2F;
      end
      return r;
   endfunction

endpackage

// ===== src/base64_stream_encoder.sv =====
// ----------------------------------------------------------------------------
// Base64 stream encoder
// Encodes a byte stream into padded base64 text, one character per transfer.
// ----------------------------------------------------------------------------
// The encoder emits one character per clock cycle at most, so its sustained
// rate is set by the output serialiser: a byte in the middle of a message
// yields one or two characters (four every three bytes), and a byte flagged
// as last yields two to four characters including padding. Bytes are
// accepted whenever the job queue has room; the first character of a byte
// passes through the queue, the job register and the output register
// before it appears. The final character of each message carries
// end_of_text, and the encoder is then at the start of a fresh group.
`timescale 1ns / 1ps
`include "base64_stream_encoder_macros.svh"
module base64_stream_encoder #(
   parameter int QUEUE_DEPTH = b64se_pkg::QueueDepthDefault
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  b64se_pkg::b64se_req_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output b64se_pkg::b64se_rsp_type rsp_payload
);
   import b64se_pkg::*;

   b64se_qstat_type q_stat;
   b64se_fstat_type f_stat;
   b64se_job_type   push_job, pop_job;
   logic            push, pop, job_valid;

   // Front end: classification and character generation.
   b64se_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .q_stat      (q_stat),
      .push        (push),
      .push_job    (push_job),
      .f_stat      (f_stat)
   );

   // Queue between the two halves.
   b64se_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .pop_job  (pop_job),
      .q_stat   (q_stat)
   );

   // Back end: serialisation to the output channel.
   b64se_back u_back (
      .clock       (clock),
      .reset       (reset),
      .pop_job     (pop_job),
      .q_stat      (q_stat),
      .pop         (pop),
      .job_valid   (job_valid),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   // A last byte always closes the group.
   `B64SE_ASSERT_NEXT(a_last_closes_group, clock, reset, req_valid && req_ready && req_payload.last_byte, f_stat.phase == PH_ZERO, "group not closed after last byte")
   // An idle serialiser picks up a waiting job at once.
   `B64SE_ASSERT_NEXT(a_back_picks_job, clock, reset, !job_valid && !q_stat.empty, job_valid, "serialiser missed a queued job")
   // The serialiser never pops an empty queue.
   `B64SE_ASSERT_NOW(a_no_pop_empty, clock, reset, pop, !q_stat.empty, "pop from empty queue")
   // The group position never reaches the unused fourth code.
   `B64SE_ASSERT_NOW(a_phase_legal, clock, reset, 1'b1, f_stat.phase <= PH_TWO, "group phase out of range")

endmodule

// ===== src/b64se_front.sv =====
// ----------------------------------------------------------------------------
// Base64 encoder front end
// Accepts bytes, tracks the group position and leftover bits, and builds a
// job holding every character that the byte produces.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module b64se_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  b64se_pkg::b64se_req_type  req_payload,
   input  b64se_pkg::b64se_qstat_type q_stat,
   output logic                   push,
   output b64se_pkg::b64se_job_type push_job,
   output b64se_pkg::b64se_fstat_type f_stat
);
   import b64se_pkg::*;

   logic [1:0] phase_ff, phase_in;
   logic [3:0] carry_ff, carry_in;
   logic [7:0] b;
   logic       last;

   assign b         = req_payload.data_byte;
   assign last      = req_payload.last_byte;
   assign req_ready = !q_stat.full;
   assign push      = req_valid && req_ready;
   assign f_stat.phase = phase_ff;

   // Build the job and the next group state from the current phase.
   always_comb begin
      push_job          = '0;
      push_job.eot      = last;
      phase_in          = PH_ZERO;
      carry_in          = 4'd0;
      unique case (phase_ff)
         PH_ONE: begin
            push_job.chars[0] = b64_sym({carry_ff[1:0], b[7:4]});
            if (last) begin
               push_job.chars[1] = b64_sym({b[3:0], 2'b00});
               push_job.chars[2] = PAD_CHAR;
               push_job.last_idx = 2'd2;
            end else begin
               push_job.last_idx = 2'd0;
               phase_in          = PH_TWO;
               carry_in          = b[3:0];
            end
         end
         PH_TWO: begin
            push_job.chars[0] = b64_sym({carry_ff, b[7:6]});
            push_job.chars[1] = b64_sym(b[5:0]);
            push_job.last_idx = 2'd1;
         end
         default: begin
            // Phase zero, and the unused fourth code, which behaves alike.
            push_job.chars[0] = b64_sym(b[7:2]);
            if (last) begin
               push_job.chars[1] = b64_sym({b[1:0], 4'b0000});
               push_job.chars[2] = PAD_CHAR;
               push_job.chars[3] = PAD_CHAR;
               push_job.last_idx = 2'd3;
            end else begin
               push_job.last_idx = 2'd0;
               phase_in          = PH_ONE;
               carry_in          = {2'b00, b[1:0]};
            end
         end
      endcase
   end

   // Group state advances on every input transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_ZERO;
         carry_ff <= 4'd0;
      end else if (push) begin
         phase_ff <= phase_in;
         carry_ff <= carry_in;
      end
   end

endmodule

// ===== src/b64se_queue.sv =====
// ----------------------------------------------------------------------------
// Base64 encoder job queue
// Small register FIFO that decouples the front end from the serialiser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module b64se_queue #(
   parameter int DEPTH = b64se_pkg::QueueDepthDefault
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  b64se_pkg::b64se_job_type  push_job,
   input  logic                      pop,
   output b64se_pkg::b64se_job_type  pop_job,
   output b64se_pkg::b64se_qstat_type q_stat
);
   import b64se_pkg::*;

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);
   localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
   localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

   b64se_job_type      entry_ff [DEPTH];
   logic [PtrW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]    count_ff, count_in;

   assign pop_job      = entry_ff[rd_ptr_ff];
   assign q_stat.full  = (count_ff == CntFull);
   assign q_stat.empty = (count_ff == '0);

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== src/b64se_back.sv =====
// ----------------------------------------------------------------------------
// Base64 encoder serialiser
// Takes jobs from the queue and sends their characters one per cycle, while
// the output is not stalled, through a registered output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module b64se_back (
   input  logic                       clock,
   input  logic                       reset,
   input  b64se_pkg::b64se_job_type   pop_job,
   input  b64se_pkg::b64se_qstat_type q_stat,
   output logic                       pop,
   output logic                       job_valid,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output b64se_pkg::b64se_rsp_type   rsp_payload
);
   import b64se_pkg::*;

   localparam int IdxW = $clog2(CharsMax);

   b64se_job_type   job_ff;
   logic            job_valid_ff, job_valid_in;
   logic [IdxW-1:0] idx_ff, idx_in;
   logic            rsp_valid_ff, rsp_valid_in;
   b64se_rsp_type   rsp_ff;
   logic            out_free, emit, job_done, job_load;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign emit      = job_valid_ff && out_free;
   assign job_done  = emit && (idx_ff == job_ff.last_idx);
   assign job_load  = (!job_valid_ff || job_done) && !q_stat.empty;
   assign pop       = job_load;
   assign job_valid = job_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Job slot and character index.
   always_comb begin
      job_valid_in = job_valid_ff;
      idx_in       = idx_ff;
      if (job_load) begin
         job_valid_in = 1'b1;
         idx_in       = '0;
      end else if (job_done) begin
         job_valid_in = 1'b0;
      end else if (emit) begin
         idx_in = idx_ff + 1'b1;
      end
      rsp_valid_in = emit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         job_valid_ff <= job_valid_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers; the end flag rides on the job's final character.
   always_ff @(posedge clock) begin
      if (job_load) begin
         job_ff <= pop_job;
      end
      if (emit) begin
         rsp_ff.out_char    <= job_ff.chars[idx_ff];
         rsp_ff.end_of_text <= job_done && job_ff.eot;
      end
   end

endmodule
